@@ src/scbh_pkg.sv @@
// shared types and constants for the substring hash compare unit
// no dependencies
package scbh_pkg;

  localparam int unsigned MAX_LEN_DEFAULT = 1048575;
  localparam int unsigned POS_W = 20;
  localparam int unsigned HASH_W = 30;
  localparam int unsigned SYM_W = 5;
  localparam logic [HASH_W-1:0] HASH_MOD = 30'd1000000007;
  localparam logic [HASH_W-1:0] HASH_BASE = 30'd31;

  localparam logic [1:0] OP_APPEND_FIRST = 2'd0;
  localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ORDER_LESS = 2'd0;
  localparam logic [1:0] ORDER_EQUAL = 2'd1;
  localparam logic [1:0] ORDER_GREATER = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] first_start;
    logic [POS_W-1:0] first_end;
    logic [POS_W-1:0] second_start;
    logic [POS_W-1:0] second_end;
  } item_in_t;

  typedef struct packed {
    logic [1:0] order;
    logic range_error;
  } item_out_t;

  // product of two residues below the modulus, reduced
  typedef struct packed {
    logic start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mul_req_t;

endpackage

@@ src/scbh_ram.sv @@
// generic single-port ram with registered read
// no dependencies
module scbh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ src/scbh_modmul.sv @@
// shift-and-add modular multiplier, one bit of b per cycle
// depends on scbh_pkg
module scbh_modmul
  import scbh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  mul_req_t req,
  output logic busy,
  output logic [HASH_W-1:0] prod
);
  logic [HASH_W-1:0] a;
  logic [HASH_W-1:0] b;
  logic [HASH_W-1:0] acc;
  logic [$clog2(HASH_W+1)-1:0] cnt;
  logic [HASH_W:0] dbl;
  logic [HASH_W-1:0] dbl_r;
  logic [HASH_W:0] sum;
  logic [HASH_W-1:0] sum_r;

  // acc = 2*acc + bit*a, msb first, the doubling and the add each reduced by one conditional subtract
  always_comb begin
    dbl = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, HASH_MOD}) ? HASH_W'(dbl - {1'b0, HASH_MOD}) : dbl[HASH_W-1:0];
    sum = {1'b0, dbl_r} + (b[HASH_W-1] ? {1'b0, a} : '0);
    sum_r = (sum >= {1'b0, HASH_MOD}) ? HASH_W'(sum - {1'b0, HASH_MOD}) : sum[HASH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      a <= req.a;
      b <= req.b;
      acc <= '0;
      cnt <= '0;
    end else if (busy) begin
      acc <= sum_r;
      b <= {b[HASH_W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
      if (cnt == ($clog2(HASH_W+1))'(HASH_W-1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign prod = acc;
endmodule

@@ src/substring_compare_by_hash_unit.sv @@
// substring compare by rolling hash: top level with sequencer and stores
// depends on scbh_pkg, scbh_ram, scbh_modmul
//
// An append reads the memories, then forms the prefix hash with one modular
// product on the shared multiplier, then writes the symbol and hash. When the
// string sets a new greatest length, a second product for the power entry
// follows on the same multiplier. Each binary search step of a query reads two
// prefix hashes of each string and one power entry through the single-port
// memories, then runs two serial modular products on the one shared multiplier.
// A bad range skips the search and answers straight from the range check.
// in_stall is high while an item is in progress or its result is waiting for
// the output register.
module substring_compare_by_hash_unit
  import scbh_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  item_in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output item_out_t out_data
);
  localparam int unsigned AW = $clog2(MAX_LEN + 1);
  localparam int unsigned DEPTH = MAX_LEN + 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 2);
  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;

  typedef enum logic [4:0] {
    S_IDLE, S_APP_RD, S_APP_WAIT, S_APP_MUL, S_APP_WR, S_PW_MUL,
    S_Q_CHECK, S_Q_LOOP, S_Q_RD1, S_Q_RD2,
    S_Q_MUL1, S_Q_MUL2, S_Q_CMP, S_Q_SYM, S_Q_SYMW1, S_Q_SYMW2, S_Q_SYM2, S_OUT
  } state_t;

  state_t state;
  item_in_t cur;
  logic [LW-1:0] len_a;
  logic [LW-1:0] len_b;
  logic [LW-1:0] filled;
  logic [LW-1:0] lo;
  logic [LW-1:0] hi;
  logic [LW-1:0] res;
  logic [LW-1:0] mid;
  logic [LW-1:0] qlen;
  logic [LW-1:0] la;
  logic [LW-1:0] lb;
  logic [HASH_W-1:0] pre_a_lo;
  logic [HASH_W-1:0] pre_a_hi;
  logic [HASH_W-1:0] pre_b_lo;
  logic [HASH_W-1:0] pre_b_hi;
  logic [HASH_W-1:0] pw;
  logic [HASH_W-1:0] prod_a;
  logic [HASH_W-1:0] old_pw;
  logic [SYM_W-1:0] sym_a;
  logic [SYM_W-1:0] sym_b;
  logic pw_new;
  logic mul_issued;
  item_out_t result;
  logic out_load;

  // memory ports
  logic sa_we, sb_we, ha_we, hb_we, pw_we;
  logic [AW-1:0] sa_addr, sb_addr, ha_addr, hb_addr, pw_addr;
  logic [SYM_W-1:0] sym_wdata, sa_rd, sb_rd;
  logic [HASH_W-1:0] h_wdata, pw_wdata, ha_rd, hb_rd, pw_rd;
  logic [HASH_W-1:0] ha_q, hb_q, pw_q;
  logic ha_zero, hb_zero, pw_one;

  mul_req_t mreq;
  logic mbusy;
  logic [HASH_W-1:0] mprod;

  scbh_ram #(.WIDTH(SYM_W), .DEPTH(DEPTH)) u_sym_a (
    .clk, .we(sa_we), .addr(sa_addr), .wdata(sym_wdata), .rdata(sa_rd));
  scbh_ram #(.WIDTH(SYM_W), .DEPTH(DEPTH)) u_sym_b (
    .clk, .we(sb_we), .addr(sb_addr), .wdata(sym_wdata), .rdata(sb_rd));
  scbh_ram #(.WIDTH(HASH_W), .DEPTH(DEPTH)) u_hash_a (
    .clk, .we(ha_we), .addr(ha_addr), .wdata(h_wdata), .rdata(ha_rd));
  scbh_ram #(.WIDTH(HASH_W), .DEPTH(DEPTH)) u_hash_b (
    .clk, .we(hb_we), .addr(hb_addr), .wdata(h_wdata), .rdata(hb_rd));
  scbh_ram #(.WIDTH(HASH_W), .DEPTH(DEPTH)) u_pow (
    .clk, .we(pw_we), .addr(pw_addr), .wdata(pw_wdata), .rdata(pw_rd));

  scbh_modmul u_mul (.clk, .rst, .req(mreq), .busy(mbusy), .prod(mprod));

  // entry zero is fixed: read it as a constant instead of clearing the memory
  assign ha_q = ha_zero ? '0 : ha_rd;
  assign hb_q = hb_zero ? '0 : hb_rd;
  assign pw_q = pw_one ? HASH_W'(1) : pw_rd;

  logic app_b;
  logic [LW-1:0] app_len;
  logic [LW-1:0] app_n;
  logic [HASH_W:0] hsum;
  logic [HASH_W-1:0] hnew;
  logic [HASH_W:0] diff_a_w;
  logic [HASH_W:0] diff_b_w;
  logic [HASH_W-1:0] rh_a;
  logic [HASH_W-1:0] rh_b;
  logic bad;

  assign app_b = (cur.op == OP_APPEND_SECOND);
  assign app_len = app_b ? len_b : len_a;
  assign app_n = app_len + 1'b1;
  assign hsum = {1'b0, mprod} + (HASH_W+1)'(cur.symbol) + 1'b1;
  assign hnew = (hsum >= {1'b0, HASH_MOD}) ? HASH_W'(hsum - {1'b0, HASH_MOD})
                                            : hsum[HASH_W-1:0];
  // (hi - prod) mod p with both below p
  assign diff_a_w = {1'b0, pre_a_hi} + ((pre_a_hi >= prod_a) ? '0 : {1'b0, HASH_MOD})
                    - {1'b0, prod_a};
  assign diff_b_w = {1'b0, pre_b_hi} + ((pre_b_hi >= mprod) ? '0 : {1'b0, HASH_MOD})
                    - {1'b0, mprod};
  assign rh_a = diff_a_w[HASH_W-1:0];
  assign rh_b = diff_b_w[HASH_W-1:0];

  assign bad = (cur.first_start == '0) || (cur.second_start == '0)
               || (cur.first_end < cur.first_start) || (cur.second_end < cur.second_start)
               || (CW'(cur.first_end) > CW'(len_a)) || (CW'(cur.second_end) > CW'(len_b));

  always_comb begin
    sa_we = 1'b0; sb_we = 1'b0; ha_we = 1'b0; hb_we = 1'b0; pw_we = 1'b0;
    sa_addr = '0; sb_addr = '0; ha_addr = '0; hb_addr = '0; pw_addr = '0;
    sym_wdata = cur.symbol;
    h_wdata = hnew;
    pw_wdata = mprod;
    mreq = '0;
    case (state)
      S_APP_RD: begin
        ha_addr = AW'(len_a);
        hb_addr = AW'(len_b);
        pw_addr = AW'(filled);
      end
      S_APP_WR: begin
        sa_we = ~app_b; sb_we = app_b;
        ha_we = ~app_b; hb_we = app_b;
        sa_addr = AW'(app_n); sb_addr = AW'(app_n);
        ha_addr = AW'(app_n); hb_addr = AW'(app_n);
      end
      S_APP_MUL: begin
        if (!mul_issued) begin
          mreq.start = 1'b1;
          mreq.a = app_b ? pre_b_lo : pre_a_lo;
          mreq.b = HASH_BASE;
        end
      end
      S_PW_MUL: begin
        if (!mul_issued) begin
          mreq.start = 1'b1;
          mreq.a = old_pw;
          mreq.b = HASH_BASE;
        end else if (!mbusy) begin
          pw_we = 1'b1;
          pw_addr = AW'(filled);
        end
      end
      S_Q_RD1: begin
        ha_addr = AW'(LW'(cur.first_start) - 1'b1);
        hb_addr = AW'(LW'(cur.second_start) - 1'b1);
        pw_addr = AW'(mid);
      end
      S_Q_RD2: begin
        ha_addr = AW'(LW'(cur.first_start) + mid - 1'b1);
        hb_addr = AW'(LW'(cur.second_start) + mid - 1'b1);
      end
      S_Q_MUL1: begin
        if (!mul_issued) begin
          mreq.start = 1'b1; mreq.a = pre_a_lo; mreq.b = pw;
        end
      end
      S_Q_MUL2: begin
        if (!mul_issued) begin
          mreq.start = 1'b1; mreq.a = pre_b_lo; mreq.b = pw;
        end
      end
      S_Q_SYM: begin
        sa_addr = AW'(LW'(cur.first_start) + res);
        sb_addr = AW'(LW'(cur.second_start) + res);
      end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);
  // a finished answer moves to the output register once it is free
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      len_a <= '0;
      len_b <= '0;
      filled <= '0;
      mul_issued <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_data <= result;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_data;
            mul_issued <= 1'b0;
            if (in_data.op == OP_QUERY) begin
              state <= S_Q_CHECK;
            end else if (in_data.op == OP_APPEND_FIRST) begin
              if (len_a < LW'(MAX_LEN)) state <= S_APP_RD;
            end else if (in_data.op == OP_APPEND_SECOND) begin
              if (len_b < LW'(MAX_LEN)) state <= S_APP_RD;
            end
          end
        end
        S_APP_RD: begin
          ha_zero <= (len_a == '0);
          hb_zero <= (len_b == '0);
          pw_one <= (filled == '0);
          state <= S_APP_WAIT;
        end
        S_APP_WAIT: begin
          pre_a_lo <= ha_q;
          pre_b_lo <= hb_q;
          old_pw <= pw_q;
          pw_new <= (app_n > filled) && (app_n > (app_b ? len_a : len_b));
          state <= S_APP_MUL;
        end
        S_APP_MUL: begin
          if (!mul_issued) begin
            mul_issued <= 1'b1;
          end else if (!mbusy) begin
            state <= S_APP_WR;
          end
        end
        S_APP_WR: begin
          if (app_b) len_b <= app_n; else len_a <= app_n;
          if (pw_new) begin
            // reuse the multiplier for the power entry
            filled <= app_n;
            mul_issued <= 1'b0;
            state <= S_PW_MUL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PW_MUL: begin
          if (!mul_issued) begin
            mul_issued <= 1'b1;
          end else if (!mbusy) begin
            state <= S_IDLE;
          end
        end
        S_Q_CHECK: begin
          la <= LW'(cur.first_end) - LW'(cur.first_start) + 1'b1;
          lb <= LW'(cur.second_end) - LW'(cur.second_start) + 1'b1;
          if (bad) begin
            result.order <= ORDER_LESS;
            result.range_error <= 1'b1;
            state <= S_OUT;
          end else begin
            lo <= LW'(1);
            res <= '0;
            state <= S_Q_SYM2;
          end
        end
        S_Q_SYM2: begin
          qlen <= (la < lb) ? la : lb;
          hi <= (la < lb) ? la : lb;
          state <= S_Q_LOOP;
        end
        S_Q_LOOP: begin
          if (lo <= hi) begin
            mid <= LW'(({1'b0, lo} + {1'b0, hi}) >> 1);
            state <= S_Q_RD1;
          end else begin
            state <= S_Q_SYM;
          end
        end
        S_Q_RD1: begin
          ha_zero <= (cur.first_start == POS_W'(1));
          hb_zero <= (cur.second_start == POS_W'(1));
          pw_one <= 1'b0;
          state <= S_Q_RD2;
        end
        S_Q_RD2: begin
          pre_a_lo <= ha_q;
          pre_b_lo <= hb_q;
          pw <= pw_q;
          ha_zero <= 1'b0;
          hb_zero <= 1'b0;
          mul_issued <= 1'b0;
          state <= S_Q_MUL1;
        end
        S_Q_MUL1: begin
          if (!mul_issued) begin
            pre_a_hi <= ha_q;
            pre_b_hi <= hb_q;
            mul_issued <= 1'b1;
          end else if (!mbusy) begin
            prod_a <= mprod;
            mul_issued <= 1'b0;
            state <= S_Q_MUL2;
          end
        end
        S_Q_MUL2: begin
          if (!mul_issued) begin
            mul_issued <= 1'b1;
          end else if (!mbusy) begin
            state <= S_Q_CMP;
          end
        end
        S_Q_CMP: begin
          if (rh_a == rh_b) begin
            res <= mid;
            lo <= mid + 1'b1;
          end else begin
            hi <= mid - 1'b1;
          end
          state <= S_Q_LOOP;
        end
        S_Q_SYM: begin
          state <= S_Q_SYMW1;
        end
        S_Q_SYMW1: begin
          sym_a <= sa_rd;
          sym_b <= sb_rd;
          state <= S_Q_SYMW2;
        end
        S_Q_SYMW2: begin
          result.range_error <= 1'b0;
          if (res == qlen) begin
            result.order <= (la == lb) ? ORDER_EQUAL : ((la < lb) ? ORDER_LESS : ORDER_GREATER);
          end else begin
            result.order <= (sym_a < sym_b) ? ORDER_LESS : ORDER_GREATER;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_len_bounded: assert property (@(posedge clk) disable iff (rst)
    (len_a <= LW'(MAX_LEN)) && (len_b <= LW'(MAX_LEN)))
    else $error("string length beyond store depth");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_filled_max: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((filled >= len_a) && (filled >= len_b)))
    else $error("power table behind string length");

endmodule

@@ test/substring_compare_by_hash_unit_tb.sv @@
// testbench for substring_compare_by_hash_unit: appends and range compare queries
// depends on scbh_pkg and the unit's rtl; predicts every answer with its own hash tables
module substring_compare_by_hash_unit_tb;
  import scbh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // small store so the full-string case is reached and queries stay short
  localparam int unsigned STORE_LEN = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint unsigned MOD64 = 64'd1000000007;
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  item_in_t in_data;
  logic out_valid;
  logic out_stall;
  item_out_t out_data;

  substring_compare_by_hash_unit #(.MAX_LEN(STORE_LEN)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // pending stimulus; drain_flag asks the sender to wait for all answers first
  item_in_t pending_items[$];
  bit drain_flags[$];
  item_out_t expected_answers[$];
  int unsigned failures = 0;
  int unsigned inputs_taken = 0;
  longint unsigned cycle_count = 0;

  // predictor copy of the block state
  bit [4:0] sym_first[int];
  bit [4:0] sym_second[int];
  longint unsigned hash_first[int];
  longint unsigned hash_second[int];
  longint unsigned powers[int];
  int len_first, len_second, powers_filled;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned span_hash(bit second, int lo, int hi);
    longint unsigned prod, top;
    prod = (second ? hash_second[lo-1] : hash_first[lo-1]) * powers[hi-lo+1];
    top = second ? hash_second[hi] : hash_first[hi];
    return (top + MOD64 * MOD64 - prod) % MOD64;
  endfunction

  task automatic store_symbol(bit second, bit [4:0] s);
    int n;
    int other;
    n = second ? len_second : len_first;
    other = second ? len_first : len_second;
    if (n >= STORE_LEN) return;
    n = n + 1;
    if (second) begin
      sym_second[n] = s;
      hash_second[n] = (hash_second[n-1] * 31 + s + 1) % MOD64;
      len_second = n;
    end else begin
      sym_first[n] = s;
      hash_first[n] = (hash_first[n-1] * 31 + s + 1) % MOD64;
      len_first = n;
    end
    if (n > powers_filled && n > other) begin
      powers[n] = (powers[n-1] * 31) % MOD64;
      powers_filled = n;
    end
  endtask

  task automatic predict_item(item_in_t it);
    int l, r, u, v, la, lb, span, lo, hi, mid, res;
    item_out_t ans;
    l = int'(it.first_start); r = int'(it.first_end);
    u = int'(it.second_start); v = int'(it.second_end);
    case (it.op)
      OP_APPEND_FIRST: store_symbol(1'b0, it.symbol);
      OP_APPEND_SECOND: store_symbol(1'b1, it.symbol);
      OP_QUERY: begin
        if (l == 0 || u == 0 || r < l || v < u || r > len_first || v > len_second) begin
          ans.order = ORDER_LESS;
          ans.range_error = 1'b1;
        end else begin
          la = r - l + 1;
          lb = v - u + 1;
          span = la < lb ? la : lb;
          lo = 1; hi = span; res = 0;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (span_hash(1'b0, l, l + mid - 1) == span_hash(1'b1, u, u + mid - 1)) begin
              res = mid;
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
          if (res == span)
            ans.order = (la == lb) ? ORDER_EQUAL : (la < lb ? ORDER_LESS : ORDER_GREATER);
          else
            ans.order = (sym_first[l+res] < sym_second[u+res]) ? ORDER_LESS : ORDER_GREATER;
          ans.range_error = 1'b0;
        end
        expected_answers.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // stimulus side bookkeeping of lengths, so valid ranges can be chosen
  int gen_first, gen_second;

  task automatic add_item(logic [1:0] op, int s, int l, int r, int u, int v,
                          bit drain = 1'b0);
    item_in_t it;
    it.op = op; it.symbol = SYM_W'(s);
    it.first_start = POS_W'(l); it.first_end = POS_W'(r);
    it.second_start = POS_W'(u); it.second_end = POS_W'(v);
    if (op == OP_APPEND_FIRST && gen_first < STORE_LEN) gen_first++;
    if (op == OP_APPEND_SECOND && gen_second < STORE_LEN) gen_second++;
    pending_items.push_back(it);
    drain_flags.push_back(drain);
  endtask

  function automatic int pick_symbol();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return $urandom_range(0, 1);
    if (k < 95) return $urandom_range(0, 25);
    return $urandom_range(26, 31);
  endfunction

  task automatic add_valid_query();
    int l, u, la, lb, k;
    l = $urandom_range(1, gen_first);
    u = $urandom_range(1, gen_second);
    la = $urandom_range(1, (gen_first - l + 1) < 16 ? gen_first - l + 1 : 16);
    lb = $urandom_range(1, (gen_second - u + 1) < 16 ? gen_second - u + 1 : 16);
    k = $urandom_range(0, 3);
    // same positions in both strings hit long common prefixes
    if (k == 0 && l <= gen_second) begin
      u = l;
      lb = (gen_second - u + 1) < la ? gen_second - u + 1 : la;
    end
    if (k == 1 && $urandom_range(0, 7) == 0) begin
      la = gen_first - l + 1;
      lb = gen_second - u + 1;
    end
    add_item(OP_QUERY, pick_symbol(), l, l + la - 1, u, u + lb - 1);
  endtask

  initial begin
    int k;
    int s;
    gen_first = 0; gen_second = 0;
    // directed part
    add_item(OP_QUERY, 0, 1, 1, 1, 1);
    add_item(OP_APPEND_FIRST, 0, 0, 0, 0, 0);
    add_item(OP_APPEND_SECOND, 0, 0, 0, 0, 0);
    add_item(OP_QUERY, 0, 1, 1, 1, 1);
    add_item(OP_APPEND_FIRST, 25, 0, 0, 0, 0);
    add_item(OP_APPEND_SECOND, 31, 0, 0, 0, 0);
    add_item(OP_APPEND_FIRST, 26, 0, 0, 0, 0);
    add_item(OP_APPEND_SECOND, 0, 0, 0, 0, 0);
    add_item(OP_APPEND_SECOND, 5, 0, 0, 0, 0);
    add_item(OP_UNUSED, 31, 'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF);
    add_item(OP_QUERY, 0, 1, 3, 1, 3);
    add_item(OP_QUERY, 0, 1, 3, 1, 4);
    add_item(OP_QUERY, 0, 1, 1, 1, 4);
    add_item(OP_QUERY, 0, 2, 3, 1, 2);
    add_item(OP_QUERY, 0, 2, 2, 2, 2);
    add_item(OP_QUERY, 0, 0, 2, 1, 2);
    add_item(OP_QUERY, 0, 1, 2, 0, 2);
    add_item(OP_QUERY, 0, 3, 2, 1, 2);
    add_item(OP_QUERY, 0, 1, 2, 3, 2);
    add_item(OP_QUERY, 0, 1, 4, 1, 2);
    add_item(OP_QUERY, 0, 1, 2, 1, 5);
    add_item(OP_QUERY, 31, 'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF, 1'b1);
    // random part
    for (int i = 0; i < 1580; i++) begin
      k = $urandom_range(0, 99);
      if (k < 22) begin
        s = pick_symbol();
        add_item(OP_APPEND_FIRST, s, 0, 0, 0, 0);
        add_item(OP_APPEND_SECOND, s, 0, 0, 0, 0);
        i++;
      end else if (k < 36) begin
        add_item(OP_APPEND_FIRST, pick_symbol(), 0, 0, 0, 0);
      end else if (k < 50) begin
        add_item(OP_APPEND_SECOND, pick_symbol(), 0, 0, 0, 0);
      end else if (k < 88 && gen_first > 0 && gen_second > 0) begin
        add_valid_query();
      end else if (k < 97) begin
        add_item(OP_QUERY, pick_symbol(), $urandom_range(0, 'hFFFFF), $urandom_range(0, 'hFFFFF),
                 $urandom_range(0, 'hFFFFF), $urandom_range(0, 'hFFFFF));
      end else begin
        add_item(OP_UNUSED, pick_symbol(), $urandom, $urandom, $urandom, $urandom);
      end
      if (i % 500 == 499) drain_flags[drain_flags.size()-1] = 1'b1;
    end
  end

  // input driver
  int unsigned send_gap = 0;
  bit waiting_drain = 1'b0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the offered item until the transfer happens
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_items.size() > 0 &&
                 (!drain_flags[0] || expected_answers.size() == 0)) begin
      in_data <= pending_items.pop_front();
      void'(drain_flags.pop_front());
      in_valid <= 1'b1;
      // runs of back-to-back items between idle stretches
      send_gap <= ((inputs_taken / 64) % 3 == 0) ? 0 : $urandom_range(0, 11);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output stall driver with one long hold-off
  int unsigned stall_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    int unsigned draw;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!hold_done && inputs_taken >= 400) begin
      hold_done <= 1'b1;
      stall_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (out_taken && stall_left == 0) begin
      draw = ((inputs_taken / 80) % 3 == 1) ? 0 : $urandom_range(0, 11);
      stall_left <= (draw > 0) ? draw - 1 : 0;
      out_stall <= (draw > 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: take transfers on both sides at the rising edge
  always @(posedge clk) begin
    item_out_t want;
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        inputs_taken++;
        predict_item(in_data);
      end
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result order=%0d range_error=%0b", $time,
                   out_data.order, out_data.range_error);
          failures++;
        end else begin
          want = expected_answers.pop_front();
          if (out_data.order !== want.order) begin
            $display("%0t: order expected %0d actual %0d", $time, want.order, out_data.order);
            failures++;
          end
          if (out_data.range_error !== want.range_error) begin
            $display("%0t: range_error expected %0b actual %0b", $time, want.range_error,
                     out_data.range_error);
            failures++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    len_first = 0; len_second = 0; powers_filled = 0;
    hash_first[0] = 0; hash_second[0] = 0; powers[0] = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (pending_items.size() == 0 && !in_valid && expected_answers.size() == 0);
    repeat (200) @(negedge clk);
    if (failures == 0 && expected_answers.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ substring_compare_by_hash_unit.f @@
src/scbh_pkg.sv
src/scbh_ram.sv
src/scbh_modmul.sv
src/substring_compare_by_hash_unit.sv
test/substring_compare_by_hash_unit_tb.sv
